FILE: rtl/ffa_pkg.sv
// Shared types and constants for the free frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

	localparam int unsigned NUM_FRAMES_DEF = 1024;
	localparam int unsigned FRAME_W        = 10;
	localparam int unsigned COUNT_W        = 11;
	localparam int unsigned STATUS_W       = 2;
	localparam int unsigned PADDR_W        = 3;
	localparam int unsigned PDATA_W        = 32;

	localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 11'd1024;

	// request kinds
	localparam logic OP_TAKE   = 1'b0;
	localparam logic OP_RETURN = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// register word index
	localparam logic REG_FRAME_COUNT = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} ffa_state_t;

	typedef struct packed {
		logic               op;
		logic [FRAME_W-1:0] frame_in;
	} ffa_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame_out;
		logic [STATUS_W-1:0] status;
	} ffa_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/free_frame_allocator.sv
// Free frame allocator: return stack in a memory over a counter of fresh frames.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  Requests enter on start/req while busy is low. req.op selects take or return;
//  req.frame_in is the frame handed back on a return.
//  Each item gives exactly one result on rsp, marked by a one-cycle done pulse;
//  the receiver cannot hold results off, so none is ever stalled.
//  A take served from the return stack needs one memory read, so its frame is
//  registered first in the read port and then in rsp, and busy is high in
//  ST_POP between the two. Every other item (fresh take, empty, return, full)
//  gives its result in the cycle after acceptance and busy stays low.
//  Throughput: one item per cycle while busy is low; a stack pop holds busy
//  high in ST_POP, bound by the single read port of the stack memory.
//  Config: frame_count at byte address 0 over the APB port, written while idle;
//  only pwdata bits 10:0 are kept, and a kept value above NUM_FRAMES acts as NUM_FRAMES.
//  Reset: stack empty, no frame given out, frame_count 1024. Stack entries are
//  never read before a return has written them, so the memory needs no clearing.
//  Status: 0 ok, 1 no free frame, 2 stack full and the returned frame dropped.
module free_frame_allocator
	import ffa_pkg::*;
#(
	parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output      logic                busy,
	input  wire ffa_req_t            req,
	output      logic                done,
	output      ffa_rsp_t            rsp,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output      logic [PDATA_W-1:0]  prdata,
	output      logic                pready
);

	localparam int unsigned AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
	localparam logic [CW-1:0] STACK_FULL = CW'(NUM_FRAMES);
	localparam logic [31:0]   NF32       = 32'(NUM_FRAMES);

	logic [FRAME_W-1:0] stack_mem [NUM_FRAMES];

	ffa_state_t         state_q, state_d;
	logic [COUNT_W-1:0] frame_count_q;
	logic [CW-1:0]      stack_count_q, stack_count_d;
	logic [COUNT_W-1:0] next_fresh_q, next_fresh_d;
	logic               done_q, done_d;
	ffa_rsp_t           rsp_q, rsp_d;
	logic [FRAME_W-1:0] rd_data_q;

	logic               accept;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      rd_addr;
	logic               fresh_avail;

	assign accept  = start && !busy;
	assign busy    = (state_q == ST_POP);
	assign done    = done_q;
	assign rsp     = rsp_q;
	assign rd_addr = AW'(stack_count_q - 1'b1);

	// fresh frame exists below both the programmed and the built frame count
	assign fresh_avail = (next_fresh_q < frame_count_q) && (32'(next_fresh_q) < NF32);

	always_comb begin
		state_d       = state_q;
		stack_count_d = stack_count_q;
		next_fresh_d  = next_fresh_q;
		done_d        = 1'b0;
		rsp_d         = '0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.op == OP_RETURN) begin
						done_d = 1'b1;
						if (stack_count_q != STACK_FULL) begin
							mem_we        = 1'b1;
							stack_count_d = stack_count_q + 1'b1;
						end else begin
							rsp_d.status = STATUS_FULL;
						end
					end else if (stack_count_q != '0) begin
						mem_re        = 1'b1;
						stack_count_d = stack_count_q - 1'b1;
						state_d       = ST_POP;
					end else if (fresh_avail) begin
						done_d          = 1'b1;
						rsp_d.frame_out = next_fresh_q[FRAME_W-1:0];
						next_fresh_d    = next_fresh_q + 1'b1;
					end else begin
						done_d       = 1'b1;
						rsp_d.status = STATUS_EMPTY;
					end
				end
			end
			ST_POP: begin
				done_d          = 1'b1;
				rsp_d.frame_out = rd_data_q;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			stack_count_q <= '0;
			next_fresh_q  <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			stack_count_q <= stack_count_d;
			next_fresh_q  <= next_fresh_d;
			done_q        <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	// return stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[stack_count_q[AW-1:0]] <= req.frame_in;
		end
		if (mem_re) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FRAME_COUNT)) begin
			frame_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FRAME_COUNT) begin
			prdata = {{(PDATA_W-COUNT_W){1'b0}}, frame_count_q};
		end
	end

endmodule

`default_nettype wire
